[hdl/assert_macros.svh]
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every edge outside reset
`define CHK_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");

// next-cycle implication
`define CHK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");

`endif

[hdl/lrsvd_pkg.sv]
package lrsvd_pkg;

  // request modes
  localparam logic [1:0] MODE_LOAD_U = 2'd0;
  localparam logic [1:0] MODE_LOAD_S = 2'd1;
  localparam logic [1:0] MODE_LOAD_V = 2'd2;
  localparam logic [1:0] MODE_QUERY  = 2'd3;

  // register indexes
  localparam logic [1:0] REG_RANK_USED   = 2'd0;
  localparam logic [1:0] REG_STORED_RANK = 2'd1;
  localparam logic [1:0] REG_GRAY_LIMIT  = 2'd2;

  localparam int CfgWidth = 8;
  localparam int SigmaBits = 26;

  // request passed from front to back
  typedef struct packed {
    logic [1:0]  mode;
    logic [8:0]  row_index;
    logic [8:0]  col_index;
    logic [4:0]  term_index;
    logic [25:0] load_value;
  } req_t;

endpackage

[hdl/lrsvd_ram.sv]
module lrsvd_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // one write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/lrsvd_fifo.sv]
`include "assert_macros.svh"

module lrsvd_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  lrsvd_pkg::req_t    in_req,
  output logic               out_valid,
  input  logic               out_ready,
  output lrsvd_pkg::req_t    out_req
);

  lrsvd_pkg::req_t slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_req   = slots[rptr];

  // two-entry request queue
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (in_valid && in_ready) begin
        wptr <= ~wptr;
      end
      if (out_valid && out_ready) begin
        rptr <= ~rptr;
      end
      count <= count + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      slots[wptr] <= in_req;
    end
  end

  `CHK_IMPL(a_count_range, 1'b1, count <= 2'd2)
  `CHK_IMPL(a_ptr_match, count == 2'd0 || count == 2'd2, wptr == rptr)
  `CHK_IMPL(a_empty_ready, count == 2'd0, in_ready)

endmodule

[hdl/lrsvd_engine.sv]
`include "assert_macros.svh"

module lrsvd_engine #(
  parameter int MaxRows = 512,
  parameter int MaxCols = 512,
  parameter int MaxRank = 32,
  parameter int VecFracBits = 15
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  lrsvd_pkg::req_t req,
  input  logic [5:0]      rank_used,
  input  logic [5:0]      stored_rank,
  input  logic [7:0]      gray_limit,
  output logic            res_valid,
  input  logic            res_ready,
  output logic [7:0]      pixel,
  output logic            was_clipped
);

  localparam int VecBits  = VecFracBits + 1;
  localparam int RankBits = (MaxRank > 1) ? $clog2(MaxRank) : 1;
  localparam int CntBits  = $clog2(MaxRank + 1);
  localparam int RowBits  = (MaxRows > 1) ? $clog2(MaxRows) : 1;
  localparam int ColBits  = (MaxCols > 1) ? $clog2(MaxCols) : 1;
  localparam int UDepth   = MaxRows * MaxRank;
  localparam int VDepth   = MaxCols * MaxRank;
  localparam int UAddr    = $clog2(UDepth);
  localparam int VAddr    = $clog2(VDepth);
  localparam int SumFrac  = 2 * VecFracBits + 8;
  localparam int ProdBits = 2 * VecBits;
  localparam int FullBits = ProdBits + lrsvd_pkg::SigmaBits + 1;

  typedef enum logic [2:0] {IDLE, RUN, DRAIN1, DRAIN2, DONE} state_t;

  state_t state;
  logic [RowBits-1:0]  row;
  logic [ColBits-1:0]  col;
  logic [CntBits-1:0]  k_terms;
  logic [CntBits-1:0]  issue_cnt;
  logic [RankBits-1:0] term_rd;
  logic                iss_v, mul_v;
  logic signed [ProdBits-1:0] uv_prod;
  logic [lrsvd_pkg::SigmaBits-1:0] sig_d;
  logic signed [63:0]  acc;
  logic signed [63:0]  acc_next;

  // RAM ports
  logic [UAddr-1:0] u_waddr, u_raddr;
  logic [VAddr-1:0] v_waddr, v_raddr;
  logic [RankBits-1:0] s_waddr;
  logic u_we, v_we, s_we;
  logic [VecBits-1:0] u_rd, v_rd;
  logic [lrsvd_pkg::SigmaBits-1:0] s_rd;

  logic [5:0] k_cap;
  logic row_ok, col_ok, term_ok, load_go, q_go;

  assign row_ok  = 32'(req.row_index) < MaxRows;
  assign col_ok  = 32'(req.col_index) < MaxCols;
  assign term_ok = 32'(req.term_index) < MaxRank;
  assign req_ready = (state == IDLE);
  assign load_go = req_valid && req_ready && (req.mode != lrsvd_pkg::MODE_QUERY);
  assign q_go    = req_valid && req_ready && (req.mode == lrsvd_pkg::MODE_QUERY);

  assign u_we = load_go && req.mode == lrsvd_pkg::MODE_LOAD_U && row_ok && term_ok;
  assign v_we = load_go && req.mode == lrsvd_pkg::MODE_LOAD_V && col_ok && term_ok;
  assign s_we = load_go && req.mode == lrsvd_pkg::MODE_LOAD_S && term_ok;
  assign u_waddr = UAddr'(32'(req.row_index) * MaxRank + 32'(req.term_index));
  assign v_waddr = VAddr'(32'(req.col_index) * MaxRank + 32'(req.term_index));
  assign s_waddr = RankBits'(req.term_index);
  assign u_raddr = UAddr'(32'(row) * MaxRank + 32'(term_rd));
  assign v_raddr = VAddr'(32'(col) * MaxRank + 32'(term_rd));

  lrsvd_ram #(.Width(VecBits), .Depth(UDepth)) u_ram (
    .clk, .we(u_we), .waddr(u_waddr), .wdata(req.load_value[VecBits-1:0]),
    .raddr(u_raddr), .rdata(u_rd));
  lrsvd_ram #(.Width(VecBits), .Depth(VDepth)) v_ram (
    .clk, .we(v_we), .waddr(v_waddr), .wdata(req.load_value[VecBits-1:0]),
    .raddr(v_raddr), .rdata(v_rd));
  lrsvd_ram #(.Width(lrsvd_pkg::SigmaBits), .Depth(MaxRank)) s_ram (
    .clk, .we(s_we), .waddr(s_waddr),
    .wdata(req.load_value[lrsvd_pkg::SigmaBits-1:0]),
    .raddr(term_rd), .rdata(s_rd));

  // term count: min of both ranks and the store depth, zero off the image
  always_comb begin
    k_cap = (rank_used > stored_rank) ? stored_rank : rank_used;
    if (32'(k_cap) > MaxRank) begin
      k_cap = 6'(MaxRank);
    end
    if (!row_ok || !col_ok) begin
      k_cap = 6'd0;
    end
  end

  // accumulate the sigma-scaled product
  always_comb begin
    logic signed [FullBits-1:0] full;
    full = FullBits'(uv_prod) * $signed({1'b0, sig_d});
    acc_next = acc + 64'(full);
  end

  // output clamp and rounding
  logic [7:0] pix_c;
  logic       clip_c;
  always_comb begin
    logic [63:0] top;
    logic [63:0] rnd;
    top = 64'(gray_limit) << SumFrac;
    rnd = (64'(acc) + (64'd1 << (SumFrac - 1))) >> SumFrac;
    if (acc[63]) begin
      pix_c = 8'd0;
      clip_c = 1'b1;
    end else if (64'(acc) > top) begin
      pix_c = gray_limit;
      clip_c = 1'b1;
    end else begin
      pix_c = rnd[7:0];
      clip_c = 1'b0;
    end
  end

  // sequencer: issue reads, multiply, accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      iss_v <= 1'b0;
      mul_v <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      iss_v <= 1'b0;
      mul_v <= iss_v;
      case (state)
        IDLE: begin
          if (q_go) begin
            row <= RowBits'(req.row_index);
            col <= ColBits'(req.col_index);
            k_terms <= CntBits'(k_cap);
            issue_cnt <= '0;
            term_rd <= '0;
            acc <= '0;
            state <= RUN;
          end
        end
        RUN: begin
          if (issue_cnt == k_terms) begin
            state <= DRAIN1;
          end else begin
            iss_v <= 1'b1;
            issue_cnt <= issue_cnt + 1'b1;
          end
        end
        DRAIN1: state <= DRAIN2;
        DRAIN2: begin
          if (!mul_v && !iss_v) begin
            state <= DONE;
            res_valid <= 1'b1;
            pixel <= pix_c;
            was_clipped <= clip_c;
          end
        end
        DONE: begin
          if (res_ready) begin
            res_valid <= 1'b0;
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
      if (iss_v) begin
        uv_prod <= $signed(u_rd) * $signed(v_rd);
        sig_d <= s_rd;
      end
      if (mul_v) begin
        acc <= acc_next;
      end
      if (state == RUN && issue_cnt != k_terms) begin
        term_rd <= term_rd + 1'b1;
      end
    end
  end

  // ram read data is registered behind the read address; iss_v marks data ready
  `CHK_IMPL(a_res_done, res_valid, state == DONE)
  `CHK_NEXT(a_ready_idle, req_ready && !q_go, !res_valid)
  `CHK_IMPL(a_no_issue_idle, state == IDLE, !iss_v)

endmodule

[hdl/low_rank_svd_pixel_reconstruct_top.sv]
// a query walks k terms, k = min(rank_used, stored_rank, MAX_RANK), or zero for
// a pixel off the image, with one multiply-accumulate per term; loads are taken
// one per cycle while no query is in progress or waiting on out_ready
// a two-entry request queue lets requests arrive while a query runs
// rst is synchronous: config returns to rank 1, stored rank 32, gray limit 255
// vector and sigma memories are not cleared and hold garbage until written
module low_rank_svd_pixel_reconstruct_top #(
  parameter int MAX_ROWS = 512,
  parameter int MAX_COLS = 512,
  parameter int MAX_RANK = 32,
  parameter int VEC_FRAC_BITS = 15
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [8:0]  row_index,
  input  logic [8:0]  col_index,
  input  logic [4:0]  term_index,
  input  logic signed [25:0] load_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  pixel,
  output logic        was_clipped,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [lrsvd_pkg::CfgWidth-1:0] cfg_data
);

  logic [5:0] rank_used;
  logic [5:0] stored_rank;
  logic [7:0] gray_limit;
  lrsvd_pkg::req_t in_req, q_req;
  logic q_valid, q_ready;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rank_used   <= 6'd1;
      stored_rank <= 6'd32;
      gray_limit  <= 8'd255;
    end else if (cfg_we) begin
      case (cfg_index)
        lrsvd_pkg::REG_RANK_USED:   rank_used <= cfg_data[5:0];
        lrsvd_pkg::REG_STORED_RANK: stored_rank <= cfg_data[5:0];
        lrsvd_pkg::REG_GRAY_LIMIT:  gray_limit <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign in_req = '{mode: mode, row_index: row_index, col_index: col_index,
                    term_index: term_index, load_value: load_value};

  // front: request queue
  lrsvd_fifo u_fifo (
    .clk, .rst, .in_valid, .in_ready, .in_req,
    .out_valid(q_valid), .out_ready(q_ready), .out_req(q_req));

  // back: loads and term walk
  lrsvd_engine #(.MaxRows(MAX_ROWS), .MaxCols(MAX_COLS), .MaxRank(MAX_RANK),
                 .VecFracBits(VEC_FRAC_BITS)) u_engine (
    .clk, .rst, .req_valid(q_valid), .req_ready(q_ready), .req(q_req),
    .rank_used, .stored_rank, .gray_limit,
    .res_valid(out_valid), .res_ready(out_ready), .pixel, .was_clipped);

endmodule

[bench/lrsvd_pixel_checker.sv]
// watches both channels and the register port, predicts every pixel and compares
module lrsvd_pixel_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [8:0]  row_index,
  input  logic [8:0]  col_index,
  input  logic [4:0]  term_index,
  input  logic signed [25:0] load_value,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  pixel,
  input  logic        was_clipped,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [lrsvd_pkg::CfgWidth-1:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  localparam int SumFrac = 38;

  typedef struct {
    logic [7:0] pixel;
    logic       clipped;
  } pixel_result_t;

  // shadow copies of the vector and sigma stores
  shortint     left_store[512][32];
  shortint     right_store[512][32];
  longint      sigma_store[32];
  logic [5:0]  rank_used;
  logic [5:0]  stored_rank;
  logic [7:0]  gray_limit;

  pixel_result_t pixel_queue[$];

  // sum of the first k terms, clamped and rounded half up
  function automatic pixel_result_t reconstruct_pixel(input logic [8:0] r,
                                                      input logic [8:0] c);
    pixel_result_t res;
    longint acc;
    longint top;
    int k;
    acc = 0;
    k = rank_used;
    if (k > stored_rank) k = stored_rank;
    if (k > 32) k = 32;
    for (int t = 0; t < k; t++)
      acc += longint'(left_store[r][t]) * longint'(right_store[c][t]) * sigma_store[t];
    top = longint'(gray_limit) <<< SumFrac;
    if (acc < 0) begin
      res.pixel = 8'd0;
      res.clipped = 1'b1;
    end else if (acc > top) begin
      res.pixel = gray_limit;
      res.clipped = 1'b1;
    end else begin
      res.pixel = 8'((acc + (64'sd1 <<< (SumFrac - 1))) >>> SumFrac);
      res.clipped = 1'b0;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    pixel_result_t exp_res;
    int errs;
    errs = 0;
    if (rst) begin
      rank_used <= 6'd1;
      stored_rank <= 6'd32;
      gray_limit <= 8'd255;
      fail_count <= 0;
      pending <= 0;
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          lrsvd_pkg::REG_RANK_USED:   rank_used <= cfg_data[5:0];
          lrsvd_pkg::REG_STORED_RANK: stored_rank <= cfg_data[5:0];
          lrsvd_pkg::REG_GRAY_LIMIT:  gray_limit <= cfg_data[7:0];
          default: ;
        endcase
      end
      // accepted request
      if (in_valid && in_ready) begin
        case (mode)
          lrsvd_pkg::MODE_LOAD_U:
            left_store[row_index][term_index] = shortint'(load_value[15:0]);
          lrsvd_pkg::MODE_LOAD_S:
            sigma_store[term_index] = longint'({38'd0, load_value[25:0]});
          lrsvd_pkg::MODE_LOAD_V:
            right_store[col_index][term_index] = shortint'(load_value[15:0]);
          lrsvd_pkg::MODE_QUERY:
            pixel_queue.push_back(reconstruct_pixel(row_index, col_index));
          default: ;
        endcase
      end
      // accepted pixel
      if (out_valid && out_ready) begin
        if (pixel_queue.size() == 0) begin
          $error("pixel %0d arrived with nothing expected", pixel);
          errs++;
        end else begin
          exp_res = pixel_queue.pop_front();
          if (pixel !== exp_res.pixel) begin
            $error("pixel: expected %0d, got %0d", exp_res.pixel, pixel);
            errs++;
          end
          if (was_clipped !== exp_res.clipped) begin
            $error("was_clipped: expected %0d, got %0d", exp_res.clipped, was_clipped);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
      pending <= pixel_queue.size();
    end
  end

endmodule

[bench/low_rank_svd_pixel_reconstruct_top_tb.sv]
module low_rank_svd_pixel_reconstruct_top_tb;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  mode = lrsvd_pkg::MODE_LOAD_U;
  logic [8:0]  row_index = '0;
  logic [8:0]  col_index = '0;
  logic [4:0]  term_index = '0;
  logic signed [25:0] load_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  pixel;
  logic        was_clipped;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = lrsvd_pkg::REG_RANK_USED;
  logic [lrsvd_pkg::CfgWidth-1:0] cfg_data = '0;
  int          fail_count;
  int          pending;

  // stimulus-side bookkeeping of which store entries hold data
  logic [31:0] u_written[512];
  logic [31:0] v_written[512];
  logic [31:0] s_written = '0;
  logic [8:0]  row_pool[8];
  logic [8:0]  col_pool[8];
  int          cur_rank = 1;
  int          cur_stored = 32;
  int          item_count = 0;
  logic        quiet = 1'b0;
  logic        hold_req = 1'b0;
  logic        hold_done = 1'b0;
  int          hold_left = 0;

  low_rank_svd_pixel_reconstruct_top uut (.*);

  lrsvd_pixel_checker checker_i (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  initial begin
    #8000000;
    $display("CHECK FAILED");
    $finish;
  end

  // pixel receiver with random stalls and one long hold-off
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= 400;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet || ($urandom_range(99) >= 30);
    end
  end

  // offer one request and wait for it to be taken
  task automatic send_req(input logic [1:0] m, input logic [8:0] r, input logic [8:0] c,
                          input logic [4:0] t, input logic [25:0] v);
    if (!quiet && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    row_index <= r;
    col_index <= c;
    term_index <= t;
    load_value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    case (m)
      lrsvd_pkg::MODE_LOAD_U: u_written[r][t] = 1'b1;
      lrsvd_pkg::MODE_LOAD_S: s_written[t] = 1'b1;
      lrsvd_pkg::MODE_LOAD_V: v_written[c][t] = 1'b1;
      default: ;
    endcase
    item_count++;
    quiet = (item_count >= 500 && item_count < 700);
    if (item_count == 300) hold_req <= 1'b1;
  endtask

  // sender pause until every pixel is back, then let loads settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic set_config(input int ru, input int sr, input int mg);
    cfg_we <= 1'b1;
    cfg_index <= lrsvd_pkg::REG_RANK_USED;
    cfg_data <= lrsvd_pkg::CfgWidth'(ru);
    @(posedge clk);
    cfg_index <= lrsvd_pkg::REG_STORED_RANK;
    cfg_data <= lrsvd_pkg::CfgWidth'(sr);
    @(posedge clk);
    cfg_index <= lrsvd_pkg::REG_GRAY_LIMIT;
    cfg_data <= lrsvd_pkg::CfgWidth'(mg);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    cur_rank = ru;
    cur_stored = sr;
  endtask

  function automatic logic [25:0] rand_vec();
    logic [25:0] v;
    v = 26'($urandom);
    if ($urandom_range(2) == 0) v[15:13] = 3'b000;
    return v;
  endfunction

  function automatic logic [25:0] rand_sigma();
    case ($urandom_range(2))
      0: return 26'($urandom_range(4095));
      1: return 26'($urandom_range(262143));
      default: return 26'($urandom);
    endcase
  endfunction

  // one random request: a query on a prepared pixel or a load of what it misses, else a random load
  task automatic random_req();
    logic [8:0] r;
    logic [8:0] c;
    logic [31:0] need;
    int k;
    int t;
    r = row_pool[$urandom_range(7)];
    c = col_pool[$urandom_range(7)];
    if ($urandom_range(99) < 45) begin
      k = cur_rank;
      if (k > cur_stored) k = cur_stored;
      if (k > 32) k = 32;
      need = (k == 32) ? '1 : ((32'd1 << k) - 1);
      if ((s_written & need) != need) begin
        for (t = 0; t < 32 && s_written[t]; t++) ;
        send_req(lrsvd_pkg::MODE_LOAD_S, 9'($urandom), 9'($urandom), 5'(t), rand_sigma());
      end else if ((u_written[r] & need) != need) begin
        for (t = 0; t < 32 && u_written[r][t]; t++) ;
        send_req(lrsvd_pkg::MODE_LOAD_U, r, 9'($urandom), 5'(t), rand_vec());
      end else if ((v_written[c] & need) != need) begin
        for (t = 0; t < 32 && v_written[c][t]; t++) ;
        send_req(lrsvd_pkg::MODE_LOAD_V, 9'($urandom), c, 5'(t), rand_vec());
      end else begin
        send_req(lrsvd_pkg::MODE_QUERY, r, c, 5'($urandom), 26'($urandom));
      end
    end else begin
      if ($urandom_range(1) == 0) r = 9'($urandom);
      if ($urandom_range(1) == 0) c = 9'($urandom);
      case ($urandom_range(2))
        0: send_req(lrsvd_pkg::MODE_LOAD_U, r, c, 5'($urandom), rand_vec());
        1: send_req(lrsvd_pkg::MODE_LOAD_S, r, c, 5'($urandom), rand_sigma());
        default: send_req(lrsvd_pkg::MODE_LOAD_V, r, c, 5'($urandom), rand_vec());
      endcase
    end
  endtask

  initial begin
    int ru_set[10];
    int sr_set[10];
    int mg_set[10];
    ru_set = '{1, 32, 63, 0, 20, 5, 32, 33, 0, 0};
    sr_set = '{32, 32, 40, 32, 0, 3, 32, 63, 0, 0};
    mg_set = '{255, 255, 200, 255, 100, 0, 1, 255, 0, 0};
    for (int i = 0; i < 512; i++) begin
      u_written[i] = '0;
      v_written[i] = '0;
    end
    row_pool[0] = 9'd0;
    row_pool[1] = 9'd511;
    col_pool[0] = 9'd0;
    col_pool[1] = 9'd511;
    for (int i = 2; i < 8; i++) begin
      row_pool[i] = 9'($urandom);
      col_pool[i] = 9'($urandom);
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: exact max gray, half-up rounding, both clip sides, vector extremes
    send_req(lrsvd_pkg::MODE_LOAD_S, 9'd0, 9'd0, 5'd0, 26'd261120);
    send_req(lrsvd_pkg::MODE_LOAD_U, 9'd0, 9'd0, 5'd0, 26'h3ff4000);
    send_req(lrsvd_pkg::MODE_LOAD_V, 9'd0, 9'd0, 5'd0, 26'h0004000);
    send_req(lrsvd_pkg::MODE_QUERY, 9'd0, 9'd0, 5'd0, 26'd0);
    send_req(lrsvd_pkg::MODE_LOAD_S, 9'd0, 9'd0, 5'd0, 26'd512);
    send_req(lrsvd_pkg::MODE_QUERY, 9'd0, 9'd0, 5'd31, 26'h3ffffff);
    send_req(lrsvd_pkg::MODE_LOAD_U, 9'd511, 9'd0, 5'd0, 26'h3ff8000);
    send_req(lrsvd_pkg::MODE_LOAD_V, 9'd0, 9'd511, 5'd0, 26'h0007fff);
    send_req(lrsvd_pkg::MODE_QUERY, 9'd511, 9'd511, 5'd0, 26'd0);
    send_req(lrsvd_pkg::MODE_QUERY, 9'd511, 9'd0, 5'd0, 26'd0);
    send_req(lrsvd_pkg::MODE_LOAD_S, 9'd0, 9'd0, 5'd0, 26'h3ffffff);
    send_req(lrsvd_pkg::MODE_QUERY, 9'd0, 9'd0, 5'd0, 26'd0);
    send_req(lrsvd_pkg::MODE_LOAD_U, 9'd0, 9'd0, 5'd0, 26'h0007fff);
    send_req(lrsvd_pkg::MODE_QUERY, 9'd0, 9'd511, 5'd0, 26'd0);
    send_req(lrsvd_pkg::MODE_LOAD_S, 9'd0, 9'd0, 5'd31, 26'd0);
    send_req(lrsvd_pkg::MODE_LOAD_U, 9'd511, 9'd0, 5'd31, 26'h0000000);
    send_req(lrsvd_pkg::MODE_LOAD_V, 9'd0, 9'd511, 5'd31, 26'h3ffffff);
    drain();

    // random phases over several register settings
    for (int p = 0; p < 10; p++) begin
      if (p >= 8) begin
        ru_set[p] = $urandom_range(63);
        sr_set[p] = $urandom_range(63);
        mg_set[p] = $urandom_range(255);
      end
      set_config(ru_set[p], sr_set[p], mg_set[p]);
      repeat (110) random_req();
      drain();
    end

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[low_rank_svd_pixel_reconstruct_top.f]
+incdir+hdl
hdl/lrsvd_pkg.sv
hdl/lrsvd_ram.sv
hdl/lrsvd_fifo.sv
hdl/lrsvd_engine.sv
hdl/low_rank_svd_pixel_reconstruct_top.sv
bench/lrsvd_pixel_checker.sv
bench/low_rank_svd_pixel_reconstruct_top_tb.sv
